/* hw/rtl/b3m_pkg.sv */
package b3m_pkg;

	// Pixels per transaction; the ports carry exactly this many lanes.
	localparam int LANES = 10;
	localparam int PIX_W = 16;
	localparam int SUM_W = 20;

	// Configuration register indexes and widths.
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 12;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam int WIDTH_W = 11;
	localparam int HEIGHT_W = 12;
	localparam logic [WIDTH_W-1:0] RST_IMAGE_WIDTH = 11'd640;
	localparam logic [HEIGHT_W-1:0] RST_IMAGE_HEIGHT = 12'd480;

	// width / LANES as multiply by round-up reciprocal, exact below 2^WIDTH_W
	localparam int DIV_MUL = 6554;
	localparam int DIV_SHIFT = 16;

	// round(2^24 / 9), mean = (sum * RECIP9 + 2^23) >> 24
	localparam int RECIP_SHIFT = 24;
	localparam logic [20:0] RECIP9 = 21'd1864135;

	function automatic logic [WIDTH_W-1:0] div_lanes(input logic [WIDTH_W-1:0] w);
		logic [26:0] p;
		p = 27'(w) * 27'(DIV_MUL);
		return p[DIV_SHIFT +: WIDTH_W];
	endfunction

	function automatic logic [PIX_W-1:0] mean9(input logic [SUM_W-1:0] s);
		logic [40:0] p;
		p = 41'(s) * 41'(RECIP9) + (41'(1) << (RECIP_SHIFT - 1));
		return p[RECIP_SHIFT +: PIX_W];
	endfunction

endpackage

/* hw/rtl/b3m_line_ram.sv */
module b3m_line_ram #(
	parameter int DEPTH = 204,
	parameter int AW = 8,
	parameter int DW = 160
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, old data on a same-address write
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* hw/rtl/box_3x3_mean_stencil_unit.sv */
// 3x3 box-mean stencil over a raster image, ten pixels per transaction. Each input
// transaction carries ten adjacent pixels of one row; results come out in the same
// raster order, trailing the input by one row plus one group. An interior pixel
// becomes the rounded mean of its 3x3 neighborhood, pixels on the image border pass
// through unchanged, and frame_end marks the last result group of a frame. Once the
// last row is in, send drain transactions (or more pixel transactions, whose pixels
// are ignored) to flush the pending results: one result per transaction. The block
// takes one transaction per clock for as long as results are taken; the rate is
// set by the line buffers, each read once and written once per cycle, and the
// result is registered in stage 1 and then in the output register.
// A register write restarts the frame and drops pending results; write only while
// idle. The width is rounded down to a multiple of ten and capped at MAX_WIDTH,
// the height is capped at MAX_HEIGHT. Line buffers need no clearing after reset.
module box_3x3_mean_stencil_unit #(
	parameter int MAX_WIDTH = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [b3m_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [b3m_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [b3m_pkg::PIX_W-1:0]       pix0,
	input  logic [b3m_pkg::PIX_W-1:0]       pix1,
	input  logic [b3m_pkg::PIX_W-1:0]       pix2,
	input  logic [b3m_pkg::PIX_W-1:0]       pix3,
	input  logic [b3m_pkg::PIX_W-1:0]       pix4,
	input  logic [b3m_pkg::PIX_W-1:0]       pix5,
	input  logic [b3m_pkg::PIX_W-1:0]       pix6,
	input  logic [b3m_pkg::PIX_W-1:0]       pix7,
	input  logic [b3m_pkg::PIX_W-1:0]       pix8,
	input  logic [b3m_pkg::PIX_W-1:0]       pix9,
	input  logic                            drain,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [b3m_pkg::PIX_W-1:0]       res0,
	output logic [b3m_pkg::PIX_W-1:0]       res1,
	output logic [b3m_pkg::PIX_W-1:0]       res2,
	output logic [b3m_pkg::PIX_W-1:0]       res3,
	output logic [b3m_pkg::PIX_W-1:0]       res4,
	output logic [b3m_pkg::PIX_W-1:0]       res5,
	output logic [b3m_pkg::PIX_W-1:0]       res6,
	output logic [b3m_pkg::PIX_W-1:0]       res7,
	output logic [b3m_pkg::PIX_W-1:0]       res8,
	output logic [b3m_pkg::PIX_W-1:0]       res9,
	output logic                            frame_end
);

	import b3m_pkg::*;

	localparam int GMAX = MAX_WIDTH / LANES;           // groups per row, upper bound
	localparam int GW = $clog2(GMAX + 1);              // group counters, hold G itself
	localparam int AW = (GMAX > 1) ? $clog2(GMAX) : 1; // line buffer address
	localparam int HW = $clog2(MAX_HEIGHT + 1);        // row counters, hold H itself
	localparam int LW = $clog2(GMAX + 2);              // input-to-output lag, up to G+1
	localparam int DW = LANES * PIX_W;

	// Groups per row from the width register: at least one, at most GMAX.
	function automatic logic [GW-1:0] calc_groups(input logic [WIDTH_W-1:0] w);
		logic [WIDTH_W-1:0] q;
		q = div_lanes(w);
		if (q == '0) begin
			return GW'(1);
		end
		if (32'(q) > GMAX) begin
			return GW'(GMAX);
		end
		return GW'(q);
	endfunction

	// Rows per frame from the height register: at least one, at most MAX_HEIGHT.
	function automatic logic [HW-1:0] calc_rows(input logic [HEIGHT_W-1:0] h);
		if (h == '0) begin
			return HW'(1);
		end
		if (32'(h) > MAX_HEIGHT) begin
			return HW'(MAX_HEIGHT);
		end
		return HW'(h);
	endfunction

	// ------------------------------------------------------------------
	// Configuration: keep the derived geometry, not the raw registers.
	// ------------------------------------------------------------------
	logic [GW-1:0] g_q;
	logic [HW-1:0] h_q;
	logic          cfg_wr;

	assign cfg_ready = 1'b1;

	always_comb begin
		case (cfg_index)
			REG_IMAGE_WIDTH:  cfg_wr = cfg_valid;
			REG_IMAGE_HEIGHT: cfg_wr = cfg_valid;
			default:          cfg_wr = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g_q <= calc_groups(RST_IMAGE_WIDTH);
			h_q <= calc_rows(RST_IMAGE_HEIGHT);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  g_q <= calc_groups(cfg_data[WIDTH_W-1:0]);
				REG_IMAGE_HEIGHT: h_q <= calc_rows(cfg_data[HEIGHT_W-1:0]);
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Handshake: input -> stage 1 (sums) -> output register (means).
	// Each stage advances when it is empty or the next one advances.
	// ------------------------------------------------------------------
	logic valid_s1;
	logic out_valid_q;
	logic out_adv;
	logic s1_adv;
	logic acc;

	assign out_adv = !out_valid_q || out_ready;
	assign s1_adv = !valid_s1 || out_adv;
	assign in_ready = s1_adv;
	assign acc = in_valid && in_ready;

	logic [PIX_W-1:0] pix_v [LANES];
	logic [DW-1:0]    pix_word;

	assign pix_v[0] = pix0;
	assign pix_v[1] = pix1;
	assign pix_v[2] = pix2;
	assign pix_v[3] = pix3;
	assign pix_v[4] = pix4;
	assign pix_v[5] = pix5;
	assign pix_v[6] = pix6;
	assign pix_v[7] = pix7;
	assign pix_v[8] = pix8;
	assign pix_v[9] = pix9;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			pix_word[l*PIX_W +: PIX_W] = pix_v[l];
		end
	end

	// ------------------------------------------------------------------
	// Position counters. col/row: next input group. ogrp/orow: next result.
	// lag counts the input groups written in the frame; it stops at G+1,
	// from where every written group releases exactly one result.
	// ------------------------------------------------------------------
	logic [GW-1:0] col_q, col_n;
	logic [HW-1:0] row_q, row_n;
	logic [GW-1:0] ogrp_q, ogrp_n;
	logic [HW-1:0] orow_q, orow_n;
	logic [LW-1:0] lag_q, lag_n;

	logic fin;         // whole frame is in, only flushing remains
	logic wr;          // this transaction writes a pixel group
	logic last_col;
	logic steady;
	logic emit;
	logic win_sel;     // result comes from the window, else from the line buffer
	logic out_last_row;
	logic out_last_grp;
	logic fend;
	logic fwd;

	assign fin = (row_q >= h_q);
	assign wr = acc && !drain && !fin;
	assign last_col = (col_q + GW'(1) == g_q);
	assign steady = (lag_q == LW'(g_q) + LW'(1));
	assign emit = acc && (fin || (wr && (steady || (last_col && row_q + HW'(1) == h_q))));
	assign win_sel = fin ? ({1'b0, orow_q} + (HW+1)'(2) == {1'b0, h_q}) : steady;
	assign out_last_row = (orow_q + HW'(1) == h_q);
	assign out_last_grp = (ogrp_q + GW'(1) == g_q);
	assign fend = out_last_row && out_last_grp;
	// result pixel is being written by this very transaction
	assign fwd = wr && (orow_q == row_q) && (ogrp_q == col_q);

	always_comb begin
		col_n = col_q;
		row_n = row_q;
		ogrp_n = ogrp_q;
		orow_n = orow_q;
		lag_n = lag_q;
		if (wr) begin
			if (last_col) begin
				col_n = '0;
				row_n = row_q + HW'(1);
			end else begin
				col_n = col_q + GW'(1);
			end
			if (!steady) begin
				lag_n = lag_q + LW'(1);
			end
		end
		if (emit) begin
			if (out_last_grp) begin
				ogrp_n = '0;
				orow_n = orow_q + HW'(1);
			end else begin
				ogrp_n = ogrp_q + GW'(1);
			end
		end
		// frame done or geometry changed: restart every position
		if ((emit && fend) || cfg_wr) begin
			col_n = '0;
			row_n = '0;
			ogrp_n = '0;
			orow_n = '0;
			lag_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			ogrp_q <= '0;
			orow_q <= '0;
			lag_q <= '0;
		end else begin
			col_q <= col_n;
			row_q <= row_n;
			ogrp_q <= ogrp_n;
			orow_q <= orow_n;
			lag_q <= lag_n;
		end
	end

	// ------------------------------------------------------------------
	// Line buffers, one word per column group. A write at group c shifts
	// the column up: upper[c] takes middle[c], middle[c] takes the input.
	// Port A reads ahead at the next input group, port B (a second copy
	// of middle) at the next result group. Read data is registered, so
	// the address is taken from the next-state counters.
	// ------------------------------------------------------------------
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr_a;
	logic [AW-1:0] raddr_b;
	logic [DW-1:0] up_rd, mid_rd_a, mid_rd_b;
	logic [DW-1:0] up_a, mid_a, mid_b;
	logic          byp_a_q, byp_b_q;
	logic [DW-1:0] byp_up_q, byp_mid_q;

	assign waddr = col_q[AW-1:0];
	assign raddr_a = col_n[AW-1:0];
	assign raddr_b = ogrp_n[AW-1:0];

	b3m_line_ram #(.DEPTH(GMAX), .AW(AW), .DW(DW)) u_upper (
		.clk(clk), .we(wr), .waddr(waddr), .wdata(mid_a),
		.raddr(raddr_a), .rdata(up_rd)
	);

	b3m_line_ram #(.DEPTH(GMAX), .AW(AW), .DW(DW)) u_middle_a (
		.clk(clk), .we(wr), .waddr(waddr), .wdata(pix_word),
		.raddr(raddr_a), .rdata(mid_rd_a)
	);

	b3m_line_ram #(.DEPTH(GMAX), .AW(AW), .DW(DW)) u_middle_b (
		.clk(clk), .we(wr), .waddr(waddr), .wdata(pix_word),
		.raddr(raddr_b), .rdata(mid_rd_b)
	);

	// Read and write of one address at the same edge: take the written word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_a_q <= 1'b0;
			byp_b_q <= 1'b0;
		end else begin
			byp_a_q <= wr && (waddr == raddr_a);
			byp_b_q <= wr && (waddr == raddr_b);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			byp_up_q <= mid_a;
			byp_mid_q <= pix_word;
		end
	end

	assign up_a = byp_a_q ? byp_up_q : up_rd;
	assign mid_a = byp_a_q ? byp_mid_q : mid_rd_a;
	assign mid_b = byp_b_q ? byp_mid_q : mid_rd_b;

	// ------------------------------------------------------------------
	// Window: the newest column group of three rows, plus the last pixel
	// of the group before it. Advance on every written group.
	// ------------------------------------------------------------------
	logic [PIX_W-1:0] win_up_q [LANES];
	logic [PIX_W-1:0] win_mid_q [LANES];
	logic [PIX_W-1:0] win_low_q [LANES];
	logic [PIX_W-1:0] prv_up_q, prv_mid_q, prv_low_q;

	always_ff @(posedge clk) begin
		if (wr) begin
			prv_up_q <= win_up_q[LANES-1];
			prv_mid_q <= win_mid_q[LANES-1];
			prv_low_q <= win_low_q[LANES-1];
			for (int l = 0; l < LANES; l++) begin
				win_up_q[l] <= up_a[l*PIX_W +: PIX_W];
				win_mid_q[l] <= mid_a[l*PIX_W +: PIX_W];
				win_low_q[l] <= pix_v[l];
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: neighborhood sums, pass-through value and border flag.
	// The right neighbor of the last lane is the incoming column; it is
	// only used when that column lies in the same rows.
	// ------------------------------------------------------------------
	logic [PIX_W-1:0] ext_up [LANES+2];
	logic [PIX_W-1:0] ext_mid [LANES+2];
	logic [PIX_W-1:0] ext_low [LANES+2];
	logic [SUM_W-1:0] sum_c [LANES];
	logic [PIX_W-1:0] pass_c [LANES];
	logic [LANES-1:0] edge_c;
	logic             row_edge;

	assign row_edge = (orow_q == '0) || out_last_row;

	always_comb begin
		ext_up[0] = prv_up_q;
		ext_mid[0] = prv_mid_q;
		ext_low[0] = prv_low_q;
		for (int l = 0; l < LANES; l++) begin
			ext_up[l+1] = win_up_q[l];
			ext_mid[l+1] = win_mid_q[l];
			ext_low[l+1] = win_low_q[l];
		end
		ext_up[LANES+1] = up_a[PIX_W-1:0];
		ext_mid[LANES+1] = mid_a[PIX_W-1:0];
		ext_low[LANES+1] = pix_v[0];
		for (int l = 0; l < LANES; l++) begin
			sum_c[l] = SUM_W'(ext_up[l]) + SUM_W'(ext_up[l+1]) + SUM_W'(ext_up[l+2])
				+ SUM_W'(ext_mid[l]) + SUM_W'(ext_mid[l+1]) + SUM_W'(ext_mid[l+2])
				+ SUM_W'(ext_low[l]) + SUM_W'(ext_low[l+1]) + SUM_W'(ext_low[l+2]);
			if (win_sel) begin
				pass_c[l] = win_mid_q[l];
			end else if (fwd) begin
				pass_c[l] = pix_v[l];
			end else begin
				pass_c[l] = mid_b[l*PIX_W +: PIX_W];
			end
			edge_c[l] = row_edge
				|| ((ogrp_q == '0) && (l == 0))
				|| (out_last_grp && (l == LANES - 1));
		end
	end

	logic [SUM_W-1:0] sum_s1 [LANES];
	logic [PIX_W-1:0] pass_s1 [LANES];
	logic [LANES-1:0] edge_s1;
	logic             fend_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_adv) begin
			valid_s1 <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && emit) begin
			sum_s1 <= sum_c;
			pass_s1 <= pass_c;
			edge_s1 <= edge_c;
			fend_s1 <= fend;
		end
	end

	// ------------------------------------------------------------------
	// Output register: mean by reciprocal multiply, or the pixel itself
	// on the border. Hold while the consumer stalls.
	// ------------------------------------------------------------------
	logic [PIX_W-1:0] res_c [LANES];
	logic [PIX_W-1:0] res_q [LANES];
	logic             frame_end_q;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			res_c[l] = edge_s1[l] ? pass_s1[l] : mean9(sum_s1[l]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && valid_s1) begin
			res_q <= res_c;
			frame_end_q <= fend_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign frame_end = frame_end_q;
	assign res0 = res_q[0];
	assign res1 = res_q[1];
	assign res2 = res_q[2];
	assign res3 = res_q[3];
	assign res4 = res_q[4];
	assign res5 = res_q[5];
	assign res6 = res_q[6];
	assign res7 = res_q[7];
	assign res8 = res_q[8];
	assign res9 = res_q[9];

endmodule
